### design/stf_pkg.sv
// Shared constants for the scanline triangle fill core.
`timescale 1ns / 1ps
package stf_pkg;
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int SCR_BITS       = 12;
  localparam int COLOR_BITS     = 32;

  // Reset screen size.
  localparam logic [SCR_BITS-1:0] SCR_W_RST = 12'd800;
  localparam logic [SCR_BITS-1:0] SCR_H_RST = 12'd600;

  // Configuration register indexes.
  localparam logic CFG_SCR_W = 1'b0;
  localparam logic CFG_SCR_H = 1'b1;

  // Input beat kinds carried in tuser.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;
endpackage

### design/stf_div.sv
// Iterative signed by unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module stf_div #(
  parameter int DW = 30,
  parameter int RW = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic        [RW-1:0] divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic signed [DW-1:0] quot_o
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] n_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic          busy_r;
  logic          done_r;

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;
  logic [RW-1:0] rem_nxt;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    trial   = {rem_r, n_r[DW-1]};
    diff    = trial - {1'b0, d_r};
    ge      = (trial >= {1'b0, d_r});
    rem_nxt = ge ? diff[RW-1:0] : trial[RW-1:0];
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient bits replace the dividend bits as they shift out.
  always_ff @(posedge clk) begin
    if (start_i) begin
      n_r   <= dividend_i[DW-1] ? -dividend_i : dividend_i;
      neg_r <= dividend_i[DW-1];
      rem_r <= '0;
      d_r   <= divisor_i;
    end else if (busy_r) begin
      n_r   <= {n_r[DW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy_o = busy_r;
  assign done_o = done_r;
  assign quot_o = neg_r ? -$signed(n_r) : $signed(n_r);
endmodule

### design/scanline_triangle_fill_core.sv
// Top level of the scanline triangle fill core: sequencer, edge walker and ports.
// A load beat runs setup on the one shared divider, DW = max(2*COORD_BITS+3,
// COORD_BITS+FRAC_BITS+2) bits, 30 by default: split x, then both edge
// increments, which repeat when the walk moves to the flat-top part. A load
// with all vertices on one row skips setup. A step beat while drawing yields its
// pixel in the next cycle, one pixel per cycle while out_tready does not stall.
// rst_n is synchronous, active low: idle, screen 800 by 600, no pixel pending.
`timescale 1ns / 1ps
module scanline_triangle_fill_core #(
  parameter int COORD_BITS = stf_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = stf_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // ax, ay, bx, by, cx, cy, fill_color from bit 0 up, zero padded to bytes
  input  logic [((6*COORD_BITS+stf_pkg::COLOR_BITS+7)/8)*8-1:0] in_tdata,
  input  logic in_tuser,   // mode
  input  logic in_tvalid,
  output logic in_tready,
  // pixel_x, pixel_y, pixel_color from bit 0 up, zero padded to bytes
  output logic [((2*COORD_BITS+stf_pkg::COLOR_BITS+7)/8)*8-1:0] out_tdata,
  output logic out_tuser,  // visible
  output logic out_tlast,  // last
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_we,
  input  logic cfg_addr,
  input  logic [stf_pkg::SCR_BITS-1:0] cfg_wdata
);
  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int CB  = stf_pkg::COLOR_BITS;
  localparam int SB  = stf_pkg::SCR_BITS;
  localparam int AW  = C + F + 2;
  localparam int DWA = 2 * C + 3;
  localparam int DW  = (DWA > AW) ? DWA : AW;
  localparam int RW  = C + 1;
  localparam int VW  = ((C > SB) ? C : SB) + 1;
  localparam int ODW = ((2 * C + CB + 7) / 8) * 8;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SPLIT = 5'b00010,
    ST_INC0  = 5'b00100,
    ST_INC1  = 5'b01000,
    ST_DRAW  = 5'b10000
  } state_t;

  state_t st_r, st_nxt;
  logic   go_r, go_nxt;
  logic   top_r, top_nxt;

  logic [SB-1:0] scr_w_r, scr_h_r;

  logic signed [C-1:0]  vx_r [3];
  logic signed [C-1:0]  vy_r [3];
  logic [CB-1:0]        color_r;
  logic signed [C-1:0]  split_r;
  logic signed [C-1:0]  row_r;
  logic signed [AW-1:0] acc0_r, acc1_r, inc0_r, inc1_r;
  logic signed [C-1:0]  sp0_r, sp1_r;

  logic          out_valid_r;
  logic [C-1:0]  opx_r, opy_r;
  logic [CB-1:0] ocol_r;
  logic          ovis_r, olast_r;

  logic in_fire;
  logic is_load, is_step;

  // Truncate an edge accumulator toward zero to a whole column.
  function automatic logic signed [C-1:0] fx_trunc(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] b;
    rnd = '0;
    if (a[AW-1]) rnd = {{(AW-F){1'b0}}, {F{1'b1}}};
    b = (a + rnd) >>> F;
    return b[C-1:0];
  endfunction

  assign in_tready = ((st_r == ST_IDLE) || (st_r == ST_DRAW)) &&
                     (!out_valid_r || out_tready);
  assign in_fire = in_tvalid && in_tready;
  assign is_load = in_fire && (in_tuser == stf_pkg::MODE_LOAD);
  assign is_step = in_fire && (in_tuser == stf_pkg::MODE_STEP) && (st_r == ST_DRAW);

  // Sort the incoming vertices by y with three compare-and-swap steps.
  logic signed [C-1:0] sx [3];
  logic signed [C-1:0] sy [3];
  logic signed [C-1:0] tx, ty;
  always_comb begin
    tx = '0;
    ty = '0;
    sx[0] = in_tdata[0*C +: C];  sy[0] = in_tdata[1*C +: C];
    sx[1] = in_tdata[2*C +: C];  sy[1] = in_tdata[3*C +: C];
    sx[2] = in_tdata[4*C +: C];  sy[2] = in_tdata[5*C +: C];
    if (sy[0] > sy[1]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
    end
    if (sy[1] > sy[2]) begin
      tx = sx[1]; ty = sy[1]; sx[1] = sx[2]; sy[1] = sy[2]; sx[2] = tx; sy[2] = ty;
    end
    if (sy[0] > sy[1]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
    end
  end

  // Operands of the current part: flat bottom starts at v0, flat top at v2.
  logic signed [C-1:0] base_x, base_y;
  logic signed [C:0]   rows_s, dxa, dxb, d20, d10, dx20;
  logic signed [2*C+1:0] prod_a, prod_b;
  logic signed [DW-1:0] numer;
  always_comb begin
    base_x = top_r ? vx_r[2] : vx_r[0];
    base_y = top_r ? vy_r[2] : vy_r[0];
    rows_s = top_r ? ((C+1)'(vy_r[2]) - (C+1)'(vy_r[1]))
                   : ((C+1)'(vy_r[1]) - (C+1)'(vy_r[0]));
    dxa    = (C+1)'(vx_r[1]) - (C+1)'(base_x);
    dxb    = (C+1)'(split_r) - (C+1)'(base_x);
    d20    = (C+1)'(vy_r[2]) - (C+1)'(vy_r[0]);
    d10    = (C+1)'(vy_r[1]) - (C+1)'(vy_r[0]);
    dx20   = (C+1)'(vx_r[2]) - (C+1)'(vx_r[0]);
    prod_a = (2*C+2)'(dx20) * (2*C+2)'(d10);
    prod_b = (2*C+2)'(vx_r[0]) * (2*C+2)'(d20);
    numer  = DW'(prod_a) + DW'(prod_b);
  end

  // Shared divider operands, picked by the sequencer state.
  logic                 div_start, div_busy, div_done;
  logic signed [DW-1:0] div_num, div_quot;
  logic        [RW-1:0] div_den;
  always_comb begin
    div_start = go_r && ((st_r == ST_SPLIT) || (st_r == ST_INC0) || (st_r == ST_INC1));
    div_num   = numer;
    div_den   = d20[RW-1:0];
    case (st_r)
      ST_INC0: begin
        div_num = DW'(dxa) <<< F;
        div_den = rows_s[RW-1:0];
      end
      ST_INC1: begin
        div_num = DW'(dxb) <<< F;
        div_den = rows_s[RW-1:0];
      end
      default: begin
        div_num = numer;
        div_den = d20[RW-1:0];
      end
    endcase
  end

  stf_div #(.DW(DW), .RW(RW)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Pixel of the current step and what it tells about the walk.
  logic span_done, part_done, px_last, px_vis;
  logic signed [AW-1:0] acc0_add, acc1_add;
  always_comb begin
    span_done = (sp0_r == sp1_r);
    part_done = span_done && (row_r == vy_r[1]);
    px_last   = part_done && (top_r || (vy_r[1] == vy_r[2]));
    px_vis    = !sp0_r[C-1] && !row_r[C-1] &&
                (VW'($unsigned(sp0_r)) < VW'(scr_w_r)) &&
                (VW'($unsigned(row_r)) < VW'(scr_h_r));
    acc0_add  = acc0_r + inc0_r;
    acc1_add  = acc1_r + inc1_r;
  end

  // Sequencer.
  always_comb begin
    st_nxt  = st_r;
    go_nxt  = 1'b0;
    top_nxt = top_r;
    if (is_load) begin
      if (sy[0] == sy[2]) begin
        st_nxt = ST_IDLE;
      end else begin
        st_nxt = ST_SPLIT;
        go_nxt = 1'b1;
      end
    end else begin
      case (st_r)
        ST_SPLIT: if (div_done) begin
          st_nxt  = ST_INC0;
          go_nxt  = 1'b1;
          top_nxt = (vy_r[0] == vy_r[1]);
        end
        ST_INC0: if (div_done) begin
          st_nxt = ST_INC1;
          go_nxt = 1'b1;
        end
        ST_INC1: if (div_done) begin
          st_nxt = ST_DRAW;
        end
        ST_DRAW: if (is_step && part_done) begin
          if (!top_r && (vy_r[1] != vy_r[2])) begin
            st_nxt  = ST_INC0;
            go_nxt  = 1'b1;
            top_nxt = 1'b1;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
        default: st_nxt = st_r;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      go_r        <= 1'b0;
      top_r       <= 1'b0;
      out_valid_r <= 1'b0;
      scr_w_r     <= stf_pkg::SCR_W_RST;
      scr_h_r     <= stf_pkg::SCR_H_RST;
    end else begin
      st_r  <= st_nxt;
      go_r  <= go_nxt;
      top_r <= top_nxt;
      if (is_step) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_we && (cfg_addr == stf_pkg::CFG_SCR_W)) scr_w_r <= cfg_wdata;
      if (cfg_we && (cfg_addr == stf_pkg::CFG_SCR_H)) scr_h_r <= cfg_wdata;
    end
  end

  // Triangle setup and edge walk.
  always_ff @(posedge clk) begin
    if (is_load) begin
      for (int i = 0; i < 3; i++) begin
        vx_r[i] <= sx[i];
        vy_r[i] <= sy[i];
      end
      color_r <= in_tdata[6*C +: CB];
    end
    if (st_r == ST_SPLIT && div_done) split_r <= div_quot[C-1:0];
    if (st_r == ST_INC0 && go_r) begin
      acc0_r <= AW'(base_x) <<< F;
      acc1_r <= AW'(base_x) <<< F;
      row_r  <= base_y;
      sp0_r  <= base_x;
      sp1_r  <= base_x;
    end
    if (st_r == ST_INC0 && div_done) inc0_r <= div_quot[AW-1:0];
    if (st_r == ST_INC1 && div_done) inc1_r <= div_quot[AW-1:0];
    if (is_step) begin
      if (!span_done) begin
        sp0_r <= (sp0_r < sp1_r) ? sp0_r + 1'b1 : sp0_r - 1'b1;
      end else if (!part_done) begin
        acc0_r <= acc0_add;
        acc1_r <= acc1_add;
        row_r  <= top_r ? row_r - 1'b1 : row_r + 1'b1;
        sp0_r  <= fx_trunc(acc0_add);
        sp1_r  <= fx_trunc(acc1_add);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (is_step) begin
      opx_r   <= sp0_r;
      opy_r   <= row_r;
      ocol_r  <= color_r;
      ovis_r  <= px_vis;
      olast_r <= px_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ODW'({ocol_r, opy_r, opx_r});
  assign out_tuser  = ovis_r;
  assign out_tlast  = olast_r;

  // The input side only opens while idle or drawing.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (st_r == ST_IDLE || st_r == ST_DRAW))
    else $error("input ready outside idle or draw");

  // A divide result only lands in a setup state.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_SPLIT || st_r == ST_INC0 || st_r == ST_INC1))
    else $error("divider finished outside setup");

  // A step while drawing always leaves a pixel in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    is_step |=> out_valid_r)
    else $error("step beat lost its pixel");

  // The divider is never restarted while busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
endmodule

### test/testbench.sv
// Self-checking testbench for the scanline triangle fill core.
`timescale 1ns / 1ps
module testbench;
  localparam int CB = 12;
  localparam int FB = 16;
  localparam int SETTLE_CYCLES = 300;

  typedef enum logic [1:0] {WALK_IDLE, WALK_BOTTOM, WALK_TOP} walk_phase_t;

  typedef struct {
    logic             mode;
    logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
    logic [31:0]      color;
  } tri_beat_t;

  typedef struct {
    logic [CB-1:0] x, y;
    logic [31:0]   color;
    logic          vis, last;
  } pixel_t;

  typedef struct {
    walk_phase_t phase;
    longint      vx[3], vy[3];
    longint      split, row, acc[2], inc[2], cur, stop;
    logic [31:0] color;
    longint      scr_w, scr_h;
  } raster_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [103:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] out_tdata;
  logic out_tuser, out_tlast, out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [stf_pkg::SCR_BITS-1:0] cfg_wdata = '0;

  scanline_triangle_fill_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  tri_beat_t     pending_beats[$];
  pixel_t        expected_pixels[$];
  tri_beat_t     driven_beat;
  raster_state_t dut_shadow;
  raster_state_t plan_shadow;
  int            mismatches = 0;
  int            pixels_seen = 0;
  int            loads_sent = 0;
  int            steps_sent = 0;
  int            cycle_count = 0;
  int            hold_left = 0;
  bit            held_once = 1'b0;

  // Begins one part of the walk at vertex (x, y) toward edge ends xa and xb.
  function automatic void start_part(inout raster_state_t s, input longint x, y, xa, xb,
                                     rows);
    longint one;
    one = longint'(1) << FB;
    s.acc[0] = x * one;
    s.acc[1] = x * one;
    s.inc[0] = ((xa - x) * one) / rows;
    s.inc[1] = ((xb - x) * one) / rows;
    s.row = y;
    s.cur = s.acc[0] / one;
    s.stop = s.acc[1] / one;
  endfunction

  function automatic void start_top(inout raster_state_t s);
    if (s.vy[1] != s.vy[2]) begin
      s.phase = WALK_TOP;
      start_part(s, s.vx[2], s.vy[2], s.vx[1], s.split, s.vy[2] - s.vy[1]);
    end else begin
      s.phase = WALK_IDLE;
    end
  endfunction

  function automatic void swap_vertices(inout raster_state_t s, input int i, j);
    longint tx, ty;
    tx = s.vx[i];
    ty = s.vy[i];
    s.vx[i] = s.vx[j];
    s.vy[i] = s.vy[j];
    s.vx[j] = tx;
    s.vy[j] = ty;
  endfunction

  // Advances the rasterizer by one beat; emit tells whether a pixel comes out.
  function automatic void raster_beat(inout raster_state_t s, input tri_beat_t b,
                                      output bit emit, output pixel_t p);
    longint one;
    bit span_done, part_done;
    one = longint'(1) << FB;
    emit = 1'b0;
    p = '{default: '0};
    if (b.mode == stf_pkg::MODE_LOAD) begin
      s.vx[0] = b.ax; s.vy[0] = b.ay;
      s.vx[1] = b.bx; s.vy[1] = b.by;
      s.vx[2] = b.cx; s.vy[2] = b.cy;
      s.color = b.color;
      if (s.vy[0] > s.vy[1]) swap_vertices(s, 0, 1);
      if (s.vy[1] > s.vy[2]) swap_vertices(s, 1, 2);
      if (s.vy[0] > s.vy[1]) swap_vertices(s, 0, 1);
      if (s.vy[0] == s.vy[2]) begin
        s.split = s.vx[0];
        s.phase = WALK_IDLE;
      end else begin
        s.split = ((s.vx[2] - s.vx[0]) * (s.vy[1] - s.vy[0]) + s.vx[0] * (s.vy[2] - s.vy[0]))
                  / (s.vy[2] - s.vy[0]);
        if (s.vy[0] != s.vy[1]) begin
          s.phase = WALK_BOTTOM;
          start_part(s, s.vx[0], s.vy[0], s.vx[1], s.split, s.vy[1] - s.vy[0]);
        end else begin
          start_top(s);
        end
      end
    end else if (s.phase != WALK_IDLE) begin
      span_done = (s.cur == s.stop);
      part_done = span_done && (s.row == s.vy[1]);
      emit = 1'b1;
      p.x = s.cur[CB-1:0];
      p.y = s.row[CB-1:0];
      p.color = s.color;
      p.vis = s.cur >= 0 && s.cur < s.scr_w && s.row >= 0 && s.row < s.scr_h;
      p.last = part_done && (s.phase == WALK_TOP || s.vy[1] == s.vy[2]);
      if (!span_done) begin
        s.cur += (s.cur < s.stop) ? 1 : -1;
      end else if (part_done) begin
        if (s.phase == WALK_BOTTOM) start_top(s);
        else s.phase = WALK_IDLE;
      end else begin
        s.acc[0] += s.inc[0];
        s.acc[1] += s.inc[1];
        s.row += (s.phase == WALK_BOTTOM) ? 1 : -1;
        s.cur = s.acc[0] / one;
        s.stop = s.acc[1] / one;
      end
    end
  endfunction

  // Queues one beat and keeps the planning copy of the rasterizer in step.
  function automatic bit queue_beat(input tri_beat_t b);
    bit emit;
    pixel_t p;
    raster_beat(plan_shadow, b, emit, p);
    pending_beats.push_back(b);
    return emit && p.last;
  endfunction

  function automatic tri_beat_t step_beat();
    tri_beat_t b;
    b = '{default: '0};
    b.mode = stf_pkg::MODE_STEP;
    b.ax = CB'($urandom);
    b.color = $urandom;
    return b;
  endfunction

  // Loads a triangle and follows it with steps up to its final pixel or the cap.
  function automatic int queue_triangle(input tri_beat_t b, input int step_cap);
    int n;
    b.mode = stf_pkg::MODE_LOAD;
    void'(queue_beat(b));
    n = 1;
    while (plan_shadow.phase != WALK_IDLE && n <= step_cap) begin
      n++;
      if (queue_beat(step_beat())) break;
    end
    return n;
  endfunction

  // Random triangle inside a box of the given extent, near the origin or anywhere.
  function automatic tri_beat_t random_triangle(input int extent, input bit near_origin);
    tri_beat_t b;
    int bx0, by0;
    bx0 = near_origin ? int'($urandom_range(0, 80)) - 20
                      : int'($urandom_range(0, 4095 - extent)) - 2048;
    by0 = near_origin ? int'($urandom_range(0, 80)) - 20
                      : int'($urandom_range(0, 4095 - extent)) - 2048;
    b.mode = stf_pkg::MODE_LOAD;
    b.ax = CB'(bx0 + int'($urandom_range(0, extent)));
    b.ay = CB'(by0 + int'($urandom_range(0, extent)));
    b.bx = CB'(bx0 + int'($urandom_range(0, extent)));
    b.by = CB'(by0 + int'($urandom_range(0, extent)));
    b.cx = CB'(bx0 + int'($urandom_range(0, extent)));
    b.cy = CB'(by0 + int'($urandom_range(0, extent)));
    b.color = $urandom;
    return b;
  endfunction

  function automatic tri_beat_t make_load(input int ax, ay, bx, by, cx, cy,
                                          input logic [31:0] color);
    tri_beat_t b;
    b.mode = stf_pkg::MODE_LOAD;
    b.ax = CB'(ax); b.ay = CB'(ay); b.bx = CB'(bx);
    b.by = CB'(by); b.cx = CB'(cx); b.cy = CB'(cy);
    b.color = color;
    return b;
  endfunction

  // Input driver: predicts each accepted beat, then offers the next one.
  always @(posedge clk) begin
    bit emit;
    pixel_t p;
    bit idle_now;
    cycle_count <= cycle_count + 1;
    if (rst_n && in_tvalid && in_tready) begin
      raster_beat(dut_shadow, driven_beat, emit, p);
      if (emit) expected_pixels.push_back(p);
      if (driven_beat.mode == stf_pkg::MODE_LOAD) loads_sent++;
      else steps_sent++;
    end
    idle_now = !(cycle_count >= 3000 && cycle_count < 6000) && $urandom_range(0, 99) < 6;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_beats.size() > 0 && !idle_now) begin
        driven_beat = pending_beats.pop_front();
        in_tdata <= {driven_beat.color, driven_beat.cy, driven_beat.cx, driven_beat.by,
                     driven_beat.bx, driven_beat.ay, driven_beat.ax};
        in_tuser <= driven_beat.mode;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: random idling plus one long hold-off to back the core up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!held_once && pixels_seen >= 200) begin
      held_once <= 1'b1;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(!(cycle_count >= 3000 && cycle_count < 6000) &&
                      $urandom_range(0, 99) < 6);
    end
  end

  // Monitor: compares every pixel beat with the oldest expected pixel.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      pixels_seen <= pixels_seen + 1;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel beat: tdata %h", out_tdata);
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata !== {want.color, want.y, want.x} || out_tuser !== want.vis ||
            out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pixel mismatch: expected x %0d y %0d color %h vis %b last %b",
                     $signed(want.x), $signed(want.y), want.color, want.vis, want.last);
            $display("                got      x %0d y %0d color %h vis %b last %b",
                     $signed(out_tdata[11:0]), $signed(out_tdata[23:12]),
                     out_tdata[55:24], out_tuser, out_tlast);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_tvalid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_screen(input logic addr, input logic [stf_pkg::SCR_BITS-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == stf_pkg::CFG_SCR_W) dut_shadow.scr_w = value;
    else dut_shadow.scr_h = value;
  endtask

  // Random mix: mostly complete small triangles, some abandoned or idle noise.
  task automatic random_phase(input int beat_budget);
    int sent, r;
    sent = 0;
    while (sent < beat_budget) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        sent += queue_triangle(random_triangle(int'($urandom_range(0, 10)),
                                               1'($urandom_range(0, 1))), 300);
      end else if (r < 86) begin
        sent += queue_triangle(random_triangle(4095, 1'b0), int'($urandom_range(1, 30)));
      end else if (r < 92) begin
        sent += queue_triangle(random_triangle(int'($urandom_range(2, 10)), 1'b1),
                               int'($urandom_range(0, 20)));
      end else begin
        for (int i = 0; i < 3; i++) void'(queue_beat(step_beat()));
        sent += 3;
      end
    end
  endtask

  initial begin
    int widths[5];
    int heights[5];
    widths = '{800, 1, 4095, 2048, 40};
    heights = '{600, 1, 4095, 2048, 30};
    dut_shadow = '{phase: WALK_IDLE, default: 0};
    dut_shadow.scr_w = stf_pkg::SCR_W_RST;
    dut_shadow.scr_h = stf_pkg::SCR_H_RST;
    plan_shadow = dut_shadow;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle steps, flat cases, equal rows, extremes and abandoned loads.
    void'(queue_beat(step_beat()));
    void'(queue_triangle(make_load(-2048, 5, 2047, 5, 0, 5, 32'hFFFF_FFFF), 3));
    void'(queue_triangle(make_load(0, 0, 6, 0, 3, 4, 32'h0000_0000), 300));
    void'(queue_triangle(make_load(3, -2, 0, 3, 7, 3, 32'h1234_5678), 300));
    void'(queue_triangle(make_load(10, 8, -3, 2, 4, -1, 32'hA5A5_5A5A), 300));
    void'(queue_triangle(make_load(-2048, -2048, 2047, 2047, -2048, 2047, 32'hFFFF_FFFF), 4));
    void'(queue_triangle(make_load(2047, 2047, 2047, 2046, 2046, 2047, 32'h8000_0001), 300));
    void'(queue_triangle(make_load(798, 598, 802, 601, 799, 603, 32'h00FF_00FF), 300));
    void'(queue_triangle(make_load(-2, -1, 2, 1, 0, 2, 32'h7F7F_7F7F), 300));
    wait_drained();

    foreach (widths[p]) begin
      if (p > 0) begin
        write_screen(stf_pkg::CFG_SCR_W, stf_pkg::SCR_BITS'(widths[p]));
        write_screen(stf_pkg::CFG_SCR_H, stf_pkg::SCR_BITS'(heights[p]));
      end
      random_phase(320);
      wait_drained();
    end

    $display("covered %0d triangle loads and %0d pixel steps, %0d pixels checked",
             loads_sent, steps_sent, pixels_seen);
    $display("screen sizes swept from one pixel up to the full range, with stalls both ways");
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("testbench failed");
    $finish;
  end
endmodule
